// File: design/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  // Fixed widths of the item fields.
  localparam int PID_W     = 3;
  localparam int PID_SLOTS = 1 << PID_W;
  localparam int AMT_W     = 16;
  localparam int RES_LANES = 4;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_PROCESSES_DEF = 8;
  localparam int NUM_RESOURCES_DEF = 4;
  localparam int AMOUNT_BITS_DEF   = 16;

  // Operation codes carried in req_type.
  localparam logic [1:0] OP_NEW       = 2'd0;
  localparam logic [1:0] OP_REQUEST   = 2'd1;
  localparam logic [1:0] OP_TERMINATE = 2'd2;

  // Update that the controller broadcasts to the selected cell.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_NEW   = 2'd1,
    CMD_GRANT = 2'd2,
    CMD_KILL  = 2'd3
  } cmd_t;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    cmd_t             cmd;
    logic [PID_W-1:0] pid;
    logic             clear;
    logic             check;
  } ctl_t;

  // Flags of the token that walks down the chain.
  typedef struct packed {
    logic valid;
    logic progress;
    logic pending;
    logic hit_live;
  } tok_t;

endpackage

// File: design/bsa_cell.sv
`timescale 1ns / 1ps

module bsa_cell #(
  parameter int IDX = 0,
  parameter int NR  = bsa_pkg::NUM_RESOURCES_DEF,
  parameter int AW  = bsa_pkg::AMOUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bsa_pkg::ctl_t          ctl,
  input  logic [NR-1:0][AW-1:0]  amt,
  input  bsa_pkg::tok_t          tok_i,
  input  logic [NR-1:0][AW-1:0]  work_i,
  input  logic [NR-1:0][AW-1:0]  need_i,
  input  logic [NR-1:0][AW-1:0]  held_i,
  output bsa_pkg::tok_t          tok_o,
  output logic [NR-1:0][AW-1:0]  work_o,
  output logic [NR-1:0][AW-1:0]  need_o,
  output logic [NR-1:0][AW-1:0]  held_o
);

  localparam logic [bsa_pkg::PID_W-1:0] IDX_PID =
    bsa_pkg::PID_W'(IDX % bsa_pkg::PID_SLOTS);
  localparam bit ADDRESSABLE = (IDX < bsa_pkg::PID_SLOTS);

  logic                  live;
  logic                  done;
  logic [NR-1:0][AW-1:0] claim;
  logic [NR-1:0][AW-1:0] need;

  logic                  sel;
  logic                  fits;
  logic                  fire;
  logic [NR-1:0][AW-1:0] need_eff;
  logic [NR-1:0][AW-1:0] give;
  logic [NR-1:0][AW-1:0] work_sum;

  assign sel = ADDRESSABLE && (ctl.pid == IDX_PID);

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < NR; r++) begin
      // The requester is checked as if the request were already granted.
      need_eff[r] = sel ? (need[r] - amt[r]) : need[r];
      give[r]     = (claim[r] > need[r]) ? (claim[r] - need[r]) : '0;
      work_sum[r] = work_i[r] + (claim[r] - need_eff[r]);
      if (need_eff[r] > work_i[r]) begin
        fits = 1'b0;
      end
    end
  end

  assign fire = tok_i.valid && ctl.check && live && !done && fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= 1'b0;
      done  <= 1'b0;
      tok_o <= '0;
    end else begin
      if (ctl.clear) begin
        done <= 1'b0;
      end else if (fire) begin
        done <= 1'b1;
      end
      case (ctl.cmd)
        bsa_pkg::CMD_NEW: begin
          if (sel) live <= 1'b1;
        end
        bsa_pkg::CMD_KILL: begin
          if (sel) live <= 1'b0;
        end
        default: begin
        end
      endcase
      tok_o.valid    <= tok_i.valid;
      tok_o.progress <= tok_i.progress | fire;
      tok_o.pending  <= tok_i.pending | (live & ~(done | fire));
      tok_o.hit_live <= sel ? live : tok_i.hit_live;
    end
  end

  always_ff @(posedge clk) begin
    work_o <= fire ? work_sum : work_i;
    need_o <= sel ? need : need_i;
    held_o <= sel ? give : held_i;
    if (sel && ctl.cmd == bsa_pkg::CMD_NEW) begin
      claim <= amt;
      need  <= amt;
    end else if (sel && ctl.cmd == bsa_pkg::CMD_GRANT) begin
      for (int r = 0; r < NR; r++) begin
        need[r] <= need[r] - amt[r];
      end
    end
  end

endmodule

// File: design/bankers_safety_allocator.sv
`timescale 1ns / 1ps

// Banker's algorithm resource manager for MAX_PROCESSES process slots.
// Input items (in_valid / in_stall) carry an operation (new claim, request,
// terminate), a process slot and one amount per resource. Every item gives
// exactly one result item (out_valid / out_stall) whose status is 0 when the
// operation was accepted and 1 when it was refused. The totals of each
// resource are written through the cfg port, which is always ready.
// Each process slot lives in one cell of a chain. A token walks the chain
// one cell per cycle: a probe pass reads the addressed slot, and for a
// request every safety pass carries the work vector and finishes each live
// slot whose need fits it. An unknown operation or an out of range slot
// skips the probe pass. A request that reaches the safety check makes one
// or more safety passes, at most as many as there are live slots. One
// item is in work at a time; the next is taken as soon as the block is
// back in idle, even while the previous result waits. A stalled result
// holds in the output register and the block waits for it before it
// reports the next one. Reset clears all slots, the holdings and the
// totals.

module bankers_safety_allocator #(
  parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
  parameter int NUM_RESOURCES = bsa_pkg::NUM_RESOURCES_DEF,
  parameter int AMOUNT_BITS   = bsa_pkg::AMOUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Item input.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [bsa_pkg::PID_W-1:0]     process_id,
  input  logic [bsa_pkg::AMT_W-1:0]     amount_res0,
  input  logic [bsa_pkg::AMT_W-1:0]     amount_res1,
  input  logic [bsa_pkg::AMT_W-1:0]     amount_res2,
  input  logic [bsa_pkg::AMT_W-1:0]     amount_res3,
  // Result output.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsa_pkg::AMT_W-1:0]     cfg_data
);

  localparam int NR = NUM_RESOURCES;
  localparam int AW = AMOUNT_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PROBE  = 5'b00010,
    S_DECIDE = 5'b00100,
    S_CHECK  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t state;

  // Latched item.
  logic [1:0]                op;
  logic [bsa_pkg::PID_W-1:0] pid;
  logic [NR-1:0][AW-1:0]     amt;
  logic                      ok;

  // Shared state outside the cells.
  logic [NR-1:0][AW-1:0]     total;
  logic [NR-1:0][AW-1:0]     held;

  // What the probe pass found for the addressed slot.
  logic                      h_live;
  logic [NR-1:0][AW-1:0]     h_need;
  logic [NR-1:0][AW-1:0]     h_held;

  // Token launched into the head of the chain.
  logic                      launch;
  logic [NR-1:0][AW-1:0]     l_work;

  bsa_pkg::ctl_t             ctl;
  bsa_pkg::tok_t             tok_c  [0:MAX_PROCESSES];
  logic [NR-1:0][AW-1:0]     work_c [0:MAX_PROCESSES];
  logic [NR-1:0][AW-1:0]     need_c [0:MAX_PROCESSES];
  logic [NR-1:0][AW-1:0]     held_c [0:MAX_PROCESSES];
  logic [MAX_PROCESSES:0]    tok_vld;

  logic [bsa_pkg::RES_LANES-1:0][bsa_pkg::AMT_W-1:0] amt_port;
  logic [NR-1:0][AW-1:0]     amt_in;
  logic [NR-1:0][AW-1:0]     avail;
  logic                      pid_ok;
  logic                      op_known;
  logic                      new_ok;
  logic                      req_ok;
  logic                      finish;
  bsa_pkg::tok_t             tok_last;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign amt_port = {amount_res3, amount_res2, amount_res1, amount_res0};

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      amt_in[r] = amt_port[r][AW-1:0];
    end
  end

  assign pid_ok   = int'(process_id) < MAX_PROCESSES;
  assign op_known = (req_type == bsa_pkg::OP_NEW) || (req_type == bsa_pkg::OP_REQUEST) ||
                    (req_type == bsa_pkg::OP_TERMINATE);

  // Available is clamped at zero when a total was lowered below what is held.
  always_comb begin
    new_ok = !h_live;
    req_ok = h_live;
    for (int r = 0; r < NR; r++) begin
      avail[r] = (total[r] > held[r]) ? (total[r] - held[r]) : '0;
      if (amt[r] > total[r]) new_ok = 1'b0;
      if (amt[r] > avail[r] || amt[r] > h_need[r]) req_ok = 1'b0;
    end
  end

  // A safety pass ends the check when it finished nobody or left nobody
  // unfinished; otherwise the grown work vector goes round again.
  assign tok_last = tok_c[MAX_PROCESSES];
  assign finish   = !tok_last.progress || !tok_last.pending;

  always_comb begin
    ctl.pid   = pid;
    ctl.clear = (state == S_PROBE);
    ctl.check = (state == S_CHECK);
    ctl.cmd   = bsa_pkg::CMD_NONE;
    if (state == S_DECIDE) begin
      if (op == bsa_pkg::OP_NEW && new_ok) begin
        ctl.cmd = bsa_pkg::CMD_NEW;
      end else if (op == bsa_pkg::OP_TERMINATE && h_live) begin
        ctl.cmd = bsa_pkg::CMD_KILL;
      end
    end else if (state == S_CHECK && tok_last.valid && finish && !tok_last.pending) begin
      ctl.cmd = bsa_pkg::CMD_GRANT;
    end
  end

  // Head of the chain.
  assign tok_c[0]  = '{valid: launch, progress: 1'b0, pending: 1'b0, hit_live: 1'b0};
  assign work_c[0] = l_work;
  assign need_c[0] = '0;
  assign held_c[0] = '0;
  assign tok_vld[0] = launch;

  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    bsa_cell #(
      .IDX (i),
      .NR  (NR),
      .AW  (AW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .amt    (amt),
      .tok_i  (tok_c[i]),
      .work_i (work_c[i]),
      .need_i (need_c[i]),
      .held_i (held_c[i]),
      .tok_o  (tok_c[i+1]),
      .work_o (work_c[i+1]),
      .need_o (need_c[i+1]),
      .held_o (held_c[i+1])
    );
    assign tok_vld[i+1] = tok_c[i+1].valid;
  end

  // Configuration registers: writes beyond the resource count are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      for (int r = 0; r < NR; r++) begin
        if (cfg_index == bsa_pkg::CFG_IDX_W'(r)) begin
          total[r] <= cfg_data[AW-1:0];
        end
      end
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      // A token enters the chain for the probe pass, the first safety pass
      // and every further pass that the last one asked for.
      launch <= (state == S_IDLE && in_valid && pid_ok && op_known) ||
                (state == S_DECIDE && op == bsa_pkg::OP_REQUEST && req_ok) ||
                (state == S_CHECK && tok_last.valid && !finish);
      if (state == S_REPLY && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= req_type;
            pid <= process_id;
            amt <= amt_in;
            if (pid_ok && op_known) begin
              state  <= S_PROBE;
            end else begin
              ok    <= 1'b0;
              state <= S_REPLY;
            end
          end
        end
        S_PROBE: begin
          if (tok_last.valid) begin
            h_live <= tok_last.hit_live;
            h_need <= need_c[MAX_PROCESSES];
            h_held <= held_c[MAX_PROCESSES];
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (op)
            bsa_pkg::OP_NEW: begin
              ok    <= new_ok;
              state <= S_REPLY;
            end
            bsa_pkg::OP_TERMINATE: begin
              ok    <= h_live;
              state <= S_REPLY;
              if (h_live) begin
                for (int r = 0; r < NR; r++) begin
                  held[r] <= (held[r] > h_held[r]) ? (held[r] - h_held[r]) : '0;
                end
              end
            end
            bsa_pkg::OP_REQUEST: begin
              ok <= 1'b0;
              if (req_ok) begin
                for (int r = 0; r < NR; r++) begin
                  l_work[r] <= avail[r] - amt[r];
                end
                state <= S_CHECK;
              end else begin
                state <= S_REPLY;
              end
            end
            default: begin
              ok    <= 1'b0;
              state <= S_REPLY;
            end
          endcase
        end
        S_CHECK: begin
          if (tok_last.valid) begin
            if (finish) begin
              ok    <= !tok_last.pending;
              state <= S_REPLY;
              if (!tok_last.pending) begin
                for (int r = 0; r < NR; r++) begin
                  held[r] <= held[r] + amt[r];
                end
              end
            end else begin
              l_work <= work_c[MAX_PROCESSES];
            end
          end
        end
        S_REPLY: begin
          if (!out_valid || !out_stall) begin
            status <= !ok;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only one token may ever be in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the cell chain");

  // No token is in flight once the controller has left the passes.
  a_chain_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_REPLY) |-> (tok_vld == '0))
    else $error("token still in the chain outside a pass");

  // A result only appears after the reply step.
  a_reply_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_REPLY))
    else $error("result presented without a reply step");

  // A grant only follows a completed safety pass.
  a_grant_after_pass: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == bsa_pkg::CMD_GRANT) |=> (state == S_REPLY && ok))
    else $error("grant issued without an accepted result");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the Banker's algorithm allocator.
// A ledger class keeps its own copy of the totals, the claim and need of
// every process slot, the live flags and the granted holdings. Each item
// that the block accepts is run through the ledger, which decides whether
// the operation should be granted and queues the expected status. Every
// result item that the block hands over is compared with the oldest queued
// status.
// The run starts with a short directed sequence and then goes through
// several settings of the totals with random items. Most random items are
// built from the ledger's current state, so that claims fit the totals and
// requests fit the remaining need. That keeps several slots live and drives
// the safety check deep. The rest is noise with fully random fields.
module testbench;

  // The one code of req_type that the package does not name.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Values of the status field.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Register indexes of the totals, in the order of the register map.
  localparam logic [bsa_pkg::CFG_IDX_W-1:0] IDX_TOTAL_RES0 = 2'd0;
  localparam logic [bsa_pkg::CFG_IDX_W-1:0] IDX_TOTAL_RES1 = 2'd1;
  localparam logic [bsa_pkg::CFG_IDX_W-1:0] IDX_TOTAL_RES2 = 2'd2;
  localparam logic [bsa_pkg::CFG_IDX_W-1:0] IDX_TOTAL_RES3 = 2'd3;
  localparam logic [bsa_pkg::CFG_IDX_W-1:0] TOTAL_IDX [bsa_pkg::RES_LANES] =
    '{IDX_TOTAL_RES0, IDX_TOTAL_RES1, IDX_TOTAL_RES2, IDX_TOTAL_RES3};

  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 270;

  typedef logic [bsa_pkg::RES_LANES-1:0][bsa_pkg::AMT_W-1:0] amounts_t;

  // One operation as it crosses the input handshake.
  typedef struct packed {
    logic [1:0]                op;
    logic [bsa_pkg::PID_W-1:0] pid;
    amounts_t                  amt;
  } alloc_item_t;

  typedef struct packed {
    alloc_item_t item;
    logic        status;
  } due_status_t;

  // Ledger of the allocator: it tracks the state the block should be in and
  // queues the status each accepted item should produce.
  class grant_ledger;
    logic [bsa_pkg::AMT_W-1:0] total [bsa_pkg::RES_LANES] = '{default: '0};
    amounts_t         claim [bsa_pkg::PID_SLOTS] = '{default: '0};
    amounts_t         need  [bsa_pkg::PID_SLOTS] = '{default: '0};
    bit               live  [bsa_pkg::PID_SLOTS] = '{default: 1'b0};
    amounts_t         held = '0;
    due_status_t      due_status [$];
    int               errors = 0;

    // A total set below what is held leaves nothing available.
    function logic [bsa_pkg::AMT_W-1:0] avail(int r);
      return (total[r] > held[r]) ? total[r] - held[r] : '0;
    endfunction

    // Safety check as if the request were granted. The work vector is kept
    // at 32 bits so that sums never wrap.
    function bit grant_is_safe(int pid, amounts_t amt);
      logic [31:0] work [bsa_pkg::RES_LANES];
      logic [31:0] n;
      bit          done [bsa_pkg::PID_SLOTS];
      bit          fits;
      bit          progress;
      for (int r = 0; r < bsa_pkg::RES_LANES; r++)
        work[r] = 32'(avail(r)) - 32'(amt[r]);
      for (int s = 0; s < bsa_pkg::PID_SLOTS; s++)
        done[s] = 1'b0;
      progress = 1'b1;
      while (progress) begin
        progress = 1'b0;
        // Finish the lowest-numbered slot that fits, then scan again.
        for (int s = 0; s < bsa_pkg::PID_SLOTS && !progress; s++) begin
          if (live[s] && !done[s]) begin
            fits = 1'b1;
            for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
              n = 32'(need[s][r]);
              if (s == pid)
                n = n - 32'(amt[r]);
              if (n > work[r])
                fits = 1'b0;
            end
            if (fits) begin
              done[s] = 1'b1;
              for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
                n = 32'(need[s][r]);
                if (s == pid)
                  n = n - 32'(amt[r]);
                work[r] = work[r] + 32'(claim[s][r]) - n;
              end
              progress = 1'b1;
            end
          end
        end
      end
      for (int s = 0; s < bsa_pkg::PID_SLOTS; s++)
        if (live[s] && !done[s])
          return 1'b0;
      return 1'b1;
    endfunction

    // Applies one operation to the ledger and returns the status it earns.
    function logic decide(alloc_item_t it);
      bit                        ok;
      int                        p;
      logic [bsa_pkg::AMT_W-1:0] give;
      ok = 1'b0;
      p  = int'(it.pid);
      case (it.op)
        bsa_pkg::OP_NEW: begin
          if (!live[p]) begin
            ok = 1'b1;
            for (int r = 0; r < bsa_pkg::RES_LANES; r++)
              if (it.amt[r] > total[r])
                ok = 1'b0;
            if (ok) begin
              claim[p] = it.amt;
              need[p]  = it.amt;
              live[p]  = 1'b1;
            end
          end
        end
        bsa_pkg::OP_REQUEST: begin
          if (live[p]) begin
            ok = 1'b1;
            for (int r = 0; r < bsa_pkg::RES_LANES; r++)
              if (it.amt[r] > avail(r) || it.amt[r] > need[p][r])
                ok = 1'b0;
            if (ok)
              ok = grant_is_safe(p, it.amt);
            if (ok) begin
              for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
                need[p][r] = need[p][r] - it.amt[r];
                held[r]    = held[r] + it.amt[r];
              end
            end
          end
        end
        bsa_pkg::OP_TERMINATE: begin
          if (live[p]) begin
            ok = 1'b1;
            for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
              give    = (claim[p][r] > need[p][r]) ? claim[p][r] - need[p][r] : '0;
              held[r] = (held[r] > give) ? held[r] - give : '0;
            end
            live[p] = 1'b0;
          end
        end
        default: ;
      endcase
      return ok ? STATUS_OK : STATUS_REFUSED;
    endfunction

    function void log_item(alloc_item_t it);
      due_status_t d;
      d.item   = it;
      d.status = decide(it);
      due_status.push_back(d);
    endfunction

    function void check_status(logic actual);
      due_status_t d;
      if (due_status.size() == 0) begin
        errors++;
        $display("%0t: result item with no item outstanding: expected none, actual %0d",
                 $time, actual);
      end else begin
        d = due_status.pop_front();
        if (actual !== d.status) begin
          errors++;
          $display("%0t: status of op %0d pid %0d: expected %0d, actual %0d",
                   $time, d.item.op, d.item.pid, d.status, actual);
        end
      end
    endfunction

    function int pending();
      return due_status.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [1:0]                    req_type    = bsa_pkg::OP_NEW;
  logic [bsa_pkg::PID_W-1:0]     process_id  = '0;
  logic [bsa_pkg::AMT_W-1:0]     amount_res0 = '0;
  logic [bsa_pkg::AMT_W-1:0]     amount_res1 = '0;
  logic [bsa_pkg::AMT_W-1:0]     amount_res2 = '0;
  logic [bsa_pkg::AMT_W-1:0]     amount_res3 = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic                          status;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index   = IDX_TOTAL_RES0;
  logic [bsa_pkg::AMT_W-1:0]     cfg_data    = '0;

  grant_ledger ledger = new;

  // Set by the stimulus to ask the result side for one long hold-off.
  bit hold_req = 1'b0;
  // While set, neither side idles on purpose.
  bit quiet = 1'b0;

  bankers_safety_allocator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .process_id  (process_id),
    .amount_res0 (amount_res0),
    .amount_res1 (amount_res1),
    .amount_res2 (amount_res2),
    .amount_res3 (amount_res3),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous limit: the slowest correct run is a small fraction of this.
  initial begin
    #30_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic alloc_item_t op_item(logic [1:0] op, int pid, amounts_t amt);
    alloc_item_t it;
    it.op  = op;
    it.pid = bsa_pkg::PID_W'(pid);
    it.amt = amt;
    return it;
  endfunction

  // Random item. About a fifth is pure noise. The rest is shaped by the
  // ledger: claims for free slots within the totals, requests for live slots
  // within their need (mostly within what is available too), a few claims
  // on live slots and terminations.
  function automatic alloc_item_t random_item();
    alloc_item_t it;
    int unsigned p;
    int unsigned pick;
    int unsigned cap;
    p      = $urandom_range(0, bsa_pkg::PID_SLOTS - 1);
    pick   = $urandom_range(0, 99);
    it.pid = bsa_pkg::PID_W'(p);
    it.op  = bsa_pkg::OP_NEW;
    it.amt = '0;
    if (pick < 20) begin
      it.op = 2'($urandom_range(0, 3));
      for (int r = 0; r < bsa_pkg::RES_LANES; r++)
        it.amt[r] = bsa_pkg::AMT_W'($urandom);
    end else if (!ledger.live[p]) begin
      // A claim, now and then just over a total; otherwise a request on an
      // empty slot.
      it.op = (pick < 90) ? bsa_pkg::OP_NEW : bsa_pkg::OP_REQUEST;
      for (int r = 0; r < bsa_pkg::RES_LANES; r++)
        it.amt[r] = bsa_pkg::AMT_W'($urandom_range(0,
                      ledger.total[r] + ((pick >= 82) ? 1 : 0)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        it.op = bsa_pkg::OP_REQUEST;
        for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
          cap = ledger.need[p][r];
          if (pick < 55 && ledger.avail(r) < cap)
            cap = ledger.avail(r);
          if (pick < 25)
            cap = cap / 3;
          it.amt[r] = bsa_pkg::AMT_W'($urandom_range(0, cap));
        end
      end else if (pick < 78) begin
        it.op = bsa_pkg::OP_NEW;
        for (int r = 0; r < bsa_pkg::RES_LANES; r++)
          it.amt[r] = bsa_pkg::AMT_W'($urandom_range(0, ledger.total[r]));
      end else begin
        it.op = bsa_pkg::OP_TERMINATE;
        for (int r = 0; r < bsa_pkg::RES_LANES; r++)
          it.amt[r] = bsa_pkg::AMT_W'($urandom);
      end
    end
    return it;
  endfunction

  // Offers one item and waits until the block takes it. The ledger is
  // updated at the accepting edge, so the next item can be shaped from it.
  task automatic push_item(alloc_item_t it);
    in_valid    <= 1'b1;
    req_type    <= it.op;
    process_id  <= it.pid;
    amount_res0 <= it.amt[0];
    amount_res1 <= it.amt[1];
    amount_res2 <= it.amt[2];
    amount_res3 <= it.amt[3];
    do @(posedge clk); while (in_stall);
    ledger.log_item(it);
  endtask

  // Random gap on the input side after roughly one item in ten, long enough
  // that the sender idles in about a tenth of the cycles.
  task automatic pace_input();
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(5, 20);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0)
      @(posedge clk);
  endtask

  // Writes all four totals back to back; only called while the block is idle.
  task automatic write_totals(amounts_t t);
    for (int r = 0; r < bsa_pkg::RES_LANES; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= TOTAL_IDX[r];
      cfg_data  <= t[r];
      do @(posedge clk); while (!cfg_ready);
      ledger.total[r] = t[r];
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: checks every accepted result item and stalls at random,
  // except for one long hold-off that it counts out itself.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall)
        ledger.check_status(status);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin : stimulus
    amounts_t phase_totals [6];
    amounts_t t;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Resource 3 starts at its largest total.
    write_totals({16'd65535, 16'd7, 16'd5, 16'd10});
    // Two claims that together need twice the whole of resource 0.
    push_item(op_item(bsa_pkg::OP_NEW,       0, {16'd0, 16'd0, 16'd0, 16'd10}));
    push_item(op_item(bsa_pkg::OP_NEW,       1, {16'd0, 16'd0, 16'd0, 16'd10}));
    // A claim on a live slot is refused.
    push_item(op_item(bsa_pkg::OP_NEW,       1, {16'd1, 16'd1, 16'd1, 16'd1}));
    // Half of resource 0 to slot 0 is safe; the other half to slot 1 is not.
    push_item(op_item(bsa_pkg::OP_REQUEST,   0, {16'd0, 16'd0, 16'd0, 16'd5}));
    push_item(op_item(bsa_pkg::OP_REQUEST,   1, {16'd0, 16'd0, 16'd0, 16'd5}));
    push_item(op_item(bsa_pkg::OP_REQUEST,   1, {16'd0, 16'd0, 16'd0, 16'd0}));
    // More than is available, more than is still needed.
    push_item(op_item(bsa_pkg::OP_REQUEST,   1, {16'd0, 16'd0, 16'd0, 16'd6}));
    push_item(op_item(bsa_pkg::OP_REQUEST,   0, {16'd0, 16'd0, 16'd0, 16'd6}));
    // Request and terminate on empty slots.
    push_item(op_item(bsa_pkg::OP_REQUEST,   5, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_TERMINATE, 6, {16'd0, 16'd0, 16'd0, 16'd0}));
    // The unknown operation is refused whatever it carries.
    push_item(op_item(OP_UNKNOWN,   0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    push_item(op_item(OP_UNKNOWN,   7, {16'h0000, 16'h0000, 16'h0000, 16'h0000}));
    // Claims right at the totals, one just over, one of nothing.
    push_item(op_item(bsa_pkg::OP_NEW,       2, {16'd65535, 16'd7, 16'd5, 16'd0}));
    push_item(op_item(bsa_pkg::OP_NEW,       3, {16'd0, 16'd0, 16'd6, 16'd0}));
    push_item(op_item(bsa_pkg::OP_NEW,       7, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_REQUEST,   2, {16'd65535, 16'd7, 16'd5, 16'd0}));
    // Terminate returns the holdings; a second terminate is refused.
    push_item(op_item(bsa_pkg::OP_TERMINATE, 0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}));
    push_item(op_item(bsa_pkg::OP_TERMINATE, 0, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_TERMINATE, 2, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_REQUEST,   1, {16'd0, 16'd0, 16'd0, 16'd10}));
    push_item(op_item(bsa_pkg::OP_TERMINATE, 1, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_TERMINATE, 7, {16'd0, 16'd0, 16'd0, 16'd0}));
    push_item(op_item(bsa_pkg::OP_NEW,       4, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    drain_results();

    // Settings of the totals for the random phases. The third one drops the
    // totals below what the second phase most likely left held.
    phase_totals[0] = {16'd6, 16'd15, 16'd9, 16'd12};
    phase_totals[1] = {16'd65535, 16'd65535, 16'd65535, 16'd65535};
    phase_totals[2] = {16'd65535, 16'd0, 16'd4, 16'd0};
    for (int r = 0; r < bsa_pkg::RES_LANES; r++)
      phase_totals[3][r] = bsa_pkg::AMT_W'($urandom_range(1, 40));
    for (int r = 0; r < bsa_pkg::RES_LANES; r++)
      phase_totals[4][r] = bsa_pkg::AMT_W'($urandom);
    phase_totals[5] = {16'd1, 16'd1, 16'd1, 16'd1};

    for (int ph = 0; ph < 6; ph++) begin
      t = phase_totals[ph];
      write_totals(t);
      // One phase runs with no idling on either side.
      quiet = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Ask the result side for a long hold-off so that the block backs up.
        if (ph == 1 && n == 40)
          hold_req = 1'b1;
        push_item(random_item());
        if (ph == 0 && n == 150)
          drain_results();
        else
          pace_input();
      end
      drain_results();
    end
    quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bsa_pkg.sv
design/bsa_cell.sv
design/bankers_safety_allocator.sv
tb/testbench.sv
